/* rtl/core/sorted_priority_queue_core_macros.svh */
// Assertion macros used by the sorted priority queue checker.
// No dependencies; included by bare file name.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
// Types and codes for the sorted priority queue core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
package spq_pkg;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_spq_in;

    typedef struct packed {
        t_status            status;
        logic               removed_valid;
        logic signed [31:0] removed_value;
        logic signed [31:0] removed_priority;
        logic signed [31:0] head_value;
        logic signed [31:0] head_priority;
        logic [4:0]         entry_count;
    } t_spq_out;

    // Operation broadcast to every cell
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_bcast;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_slot;

    // What a cell shows its neighbours
    typedef struct packed {
        logic  ge;
        t_slot slot;
    } t_link;

endpackage

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue: top level with the chain of cells and the result register.
// Depends on spq_pkg and spq_cell.
//
// One command a cycle: busy never rises, and each accepted beat gives one result
// beat on the cycle after, strobed for exactly one cycle. The row of DEPTH cells
// compares the incoming priority in every slot at once and shifts in one step on
// an enqueue or a dequeue. Entries of equal priority leave in
// arrival order; an enqueue into a full queue and a dequeue from an empty one
// leave the queue as it was and say so in status.
`timescale 1ns / 1ps
module sorted_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::t_spq_in  i_item,
    output logic              o_strobe,
    output spq_pkg::t_spq_out o_result
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_link     w_link [DEPTH];
    t_slot     w_next [DEPTH];
    t_bcast    w_op;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_enq_ok;
    logic      w_deq_ok;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CW+4:0]   w_count_ext;
    logic            r_strobe;
    t_spq_out        r_result;
    t_spq_out        n_result;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_link[DEPTH-1].slot.valid;
    assign w_empty  = !w_link[0].slot.valid;
    assign w_enq_ok = w_accept && (i_item.command == CMD_ENQ) && !w_full;
    assign w_deq_ok = w_accept && (i_item.command == CMD_DEQ) && !w_empty;

    assign w_op = '{enq: w_enq_ok, deq: w_deq_ok,
                    value: i_item.item_value, prio: i_item.item_priority};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_link w_left;
        t_slot w_right;
        if (g == 0) begin : g_first
            assign w_left = '{ge: 1'b1, slot: '0};
        end else begin : g_mid
            assign w_left = w_link[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_link[g+1].slot;
        end
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g]),
            .o_next  (w_next[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_enq_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_deq_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_ext = (CW + 5)'(n_count);

    always_comb begin
        n_result = '0;
        if (i_item.command == CMD_ENQ) begin
            n_result.status = w_full ? ST_FULL : ST_DONE;
        end else begin
            n_result.status = w_empty ? ST_EMPTY : ST_DONE;
        end
        if (w_deq_ok) begin
            n_result.removed_valid    = 1'b1;
            n_result.removed_value    = w_link[0].slot.value;
            n_result.removed_priority = w_link[0].slot.prio;
        end
        if (w_next[0].valid) begin
            n_result.head_value    = w_next[0].value;
            n_result.head_priority = w_next[0].prio;
        end
        n_result.entry_count = w_count_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* rtl/core/spq_cell.sv */
// One slot of the sorted chain: holds an entry, compares it with the incoming priority.
// Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_bcast i_op,
    input  spq_pkg::t_link i_left,
    input  spq_pkg::t_slot i_right,
    output spq_pkg::t_link o_link,
    output spq_pkg::t_slot o_next
);
    import spq_pkg::*;

    logic               r_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] r_prio;
    logic               w_ge;
    t_slot              n_slot;

    // Equal priority stays ahead, so a new entry lands behind it
    assign w_ge = r_valid && (r_prio >= i_op.prio);

    always_comb begin
        n_slot = '{valid: r_valid, value: r_value, prio: r_prio};
        if (i_op.enq && !w_ge) begin
            if (i_left.ge) begin
                n_slot = '{valid: 1'b1, value: i_op.value, prio: i_op.prio};
            end else begin
                n_slot = i_left.slot;
            end
        end else if (i_op.deq) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
        r_value <= n_slot.value;
        r_prio  <= n_slot.prio;
    end

    assign o_link = '{ge: w_ge, slot: '{valid: r_valid, value: r_value, prio: r_prio}};
    assign o_next = n_slot;

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted priority queue core, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_core_macros.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_macros.svh"
module spq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input spq_pkg::t_spq_out o_result
);
    import spq_pkg::*;

    logic w_beat_in;
    logic w_deq_hit;
    logic w_empty_out;
    logic w_head_zero;

    assign w_beat_in   = i_rst_n && start && !busy;
    assign w_deq_hit   = o_strobe && o_result.removed_valid;
    assign w_empty_out = o_strobe && (o_result.entry_count == 5'd0);
    assign w_head_zero = (o_result.head_value == 32'sd0) && (o_result.head_priority == 32'sd0);

    `SPQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_beat_in, o_strobe, "a_result_follows failed")
    `SPQ_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !w_beat_in, !o_strobe, "a_no_spurious failed")
    `SPQ_ASSERT_NOW(a_removed_done, i_clk, i_rst_n, w_deq_hit, o_result.status == ST_DONE, "a_removed_done failed")
    `SPQ_ASSERT_NOW(a_empty_head, i_clk, i_rst_n, w_empty_out, w_head_zero, "a_empty_head failed")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

/* tb/sorted_priority_queue_core_tb.sv */
// Self-checking bench for sorted_priority_queue_core: directed table, then random traffic.
// Depends on spq_pkg and the core; a shadow sorted list predicts each result beat that no directed row pins.
`timescale 1ns / 1ps
module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 430;
    localparam int TAIL_CYCLES    = 5;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    typedef struct {
        bit       pinned;
        t_spq_out want;
    } t_pin;

    typedef struct {
        t_spq_in  beat;
        bit       pinned;
        t_spq_out want;
    } t_stim_row;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_spq_in  i_item  = '0;
    logic     o_strobe;
    t_spq_out o_result;

    t_entry    queue_image[$];
    t_spq_out  pending_outcomes[$];
    t_pin      pin_q[$];
    t_stim_row directed_rows[$];
    int        mismatch_count = 0;
    int        stall_cycles   = 0;

    sorted_priority_queue_core #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stable insert: after every entry of equal or higher priority
    function automatic t_spq_out apply_command(input t_spq_in beat);
        t_spq_out r;
        t_entry   e;
        int       pos;
        r        = '0;
        r.status = ST_DONE;
        if (beat.command == CMD_ENQ) begin
            if (queue_image.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < queue_image.size() &&
                       $signed(queue_image[pos].prio) >= $signed(beat.item_priority))
                    pos++;
                e.value = beat.item_value;
                e.prio  = beat.item_priority;
                queue_image.insert(pos, e);
            end
        end else if (queue_image.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e                  = queue_image.pop_front();
            r.removed_valid    = 1'b1;
            r.removed_value    = e.value;
            r.removed_priority = e.prio;
        end
        if (queue_image.size() != 0) begin
            r.head_value    = queue_image[0].value;
            r.head_priority = queue_image[0].prio;
        end
        r.entry_count = 5'(queue_image.size());
        return r;
    endfunction

    function automatic logic [31:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return 32'($urandom_range(6)) - 32'd3;
        if (sel < 62) return 32'h7FFF_FFFF;
        if (sel < 69) return 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Acceptance, prediction and result checking
    always @(posedge i_clk) begin
        bit       progress;
        t_spq_out outcome;
        t_spq_out got;
        t_pin     pin;
        progress = 1'b0;
        if (i_rst_n && start && !busy) begin
            progress = 1'b1;
            outcome  = apply_command(i_item);
            if (pin_q.size() != 0) begin
                pin = pin_q.pop_front();
                if (pin.pinned) outcome = pin.want;
            end
            pending_outcomes.push_back(outcome);
        end
        if (i_rst_n && o_strobe) begin
            progress = 1'b1;
            got      = o_result;
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'(got.entry_count), '0);
            end else begin
                outcome = pending_outcomes.pop_front();
                if (got.status !== outcome.status)
                    report_mismatch("status", 32'(got.status), 32'(outcome.status));
                if (got.removed_valid !== outcome.removed_valid)
                    report_mismatch("removed_valid", 32'(got.removed_valid),
                                    32'(outcome.removed_valid));
                if (got.removed_value !== outcome.removed_value)
                    report_mismatch("removed_value", got.removed_value, outcome.removed_value);
                if (got.removed_priority !== outcome.removed_priority)
                    report_mismatch("removed_priority", got.removed_priority,
                                    outcome.removed_priority);
                if (got.head_value !== outcome.head_value)
                    report_mismatch("head_value", got.head_value, outcome.head_value);
                if (got.head_priority !== outcome.head_priority)
                    report_mismatch("head_priority", got.head_priority, outcome.head_priority);
                if (got.entry_count !== outcome.entry_count)
                    report_mismatch("entry_count", 32'(got.entry_count),
                                    32'(outcome.entry_count));
            end
        end
        stall_cycles <= progress ? 0 : stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input t_spq_in beat, input bit pinned, input t_spq_out want);
        t_pin pin;
        pin.pinned = pinned;
        pin.want   = want;
        pin_q.push_back(pin);
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic maybe_idle(input bit allow);
        int gap;
        if (allow && $urandom_range(99) < 20) begin
            gap   = $urandom_range(1, 2);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0 || pin_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input t_cmd c, input logic [31:0] v, input logic [31:0] p);
        t_stim_row row;
        row.beat.command       = c;
        row.beat.item_value    = v;
        row.beat.item_priority = p;
        row.pinned             = 1'b0;
        row.want               = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_pinned(input t_cmd c, input logic [31:0] v, input logic [31:0] p,
                              input t_status st, input logic rv, input logic [31:0] rval,
                              input logic [31:0] rpri, input logic [31:0] hv,
                              input logic [31:0] hp, input logic [4:0] cnt);
        t_stim_row row;
        row.beat.command        = c;
        row.beat.item_value     = v;
        row.beat.item_priority  = p;
        row.pinned              = 1'b1;
        row.want.status           = st;
        row.want.removed_valid    = rv;
        row.want.removed_value    = rval;
        row.want.removed_priority = rpri;
        row.want.head_value       = hv;
        row.want.head_priority    = hp;
        row.want.entry_count      = cnt;
        directed_rows.push_back(row);
    endtask

    initial begin
        t_spq_in beat;
        int      enq_pct;
        bit      allow_idle;

        // empty, extremes, ties, full
        add_pinned(CMD_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_EMPTY, 1'b0, '0, '0, '0, '0, 5'd0);
        add_pinned(CMD_ENQ, 32'h7FFF_FFFF, 32'h8000_0000, ST_DONE, 1'b0, '0, '0,
                   32'h7FFF_FFFF, 32'h8000_0000, 5'd1);
        add_pinned(CMD_ENQ, 32'h8000_0000, 32'h7FFF_FFFF, ST_DONE, 1'b0, '0, '0,
                   32'h8000_0000, 32'h7FFF_FFFF, 5'd2);
        add_row(CMD_ENQ, 32'd1, 32'd0);
        add_row(CMD_ENQ, 32'd2, 32'd0);
        add_row(CMD_ENQ, 32'd3, 32'hFFFF_FFFF);
        add_pinned(CMD_DEQ, 32'hAAAA_AAAA, 32'h5555_5555, ST_DONE, 1'b1,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0, 5'd4);
        add_row(CMD_ENQ, 32'd4, 32'h7FFF_FFFF);
        add_row(CMD_ENQ, 32'd8, 32'h7FFF_FFFF);
        add_row(CMD_ENQ, 32'h5555_5555, 32'd0);
        add_row(CMD_ENQ, 32'hAAAA_AAAA, 32'h8000_0000);
        add_row(CMD_ENQ, 32'hFFFF_FFFF, 32'd1);
        add_row(CMD_ENQ, 32'h0000_0000, 32'hFFFF_FFFE);
        add_row(CMD_ENQ, 32'h1234_5678, 32'h7FFF_FFFE);
        add_row(CMD_ENQ, 32'h8765_4321, 32'h4000_0000);
        add_row(CMD_ENQ, 32'h0F0F_0F0F, 32'hC000_0000);
        add_row(CMD_ENQ, 32'hF0F0_F0F0, 32'd0);
        add_row(CMD_ENQ, 32'h3C3C_3C3C, 32'h8000_0000);
        add_row(CMD_ENQ, 32'hC3C3_C3C3, 32'h7FFF_FFFF);
        add_pinned(CMD_ENQ, 32'hDEAD_BEEF, 32'h7FFF_FFFF, ST_FULL, 1'b0, '0, '0,
                   32'd4, 32'h7FFF_FFFF, 5'd16);
        add_row(CMD_DEQ, 32'h0000_0000, 32'h0000_0000);
        add_row(CMD_ENQ, 32'h6666_6666, 32'h7FFF_FFFF);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            maybe_idle(1'b1);
            send_beat(directed_rows[k].beat, directed_rows[k].pinned, directed_rows[k].want);
        end
        drain_results();

        enq_pct = 50;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(4))
                    0:       enq_pct = 90;
                    1:       enq_pct = 10;
                    2:       enq_pct = 70;
                    3:       enq_pct = 30;
                    default: enq_pct = 50;
                endcase
            end
            if (k == 300) drain_results();
            allow_idle         = !(k >= 150 && k < 250);
            beat.command       = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            beat.item_value    = $urandom;
            beat.item_priority = pick_priority();
            maybe_idle(allow_idle);
            send_beat(beat, 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("result beats never arrived", 32'(pending_outcomes.size()), '0);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
